[rtl/bmp_stream_decoder_assert.svh]
// Assertion macros for the BMP stream decoder
`ifndef BMP_STREAM_DECODER_ASSERT_SVH
`define BMP_STREAM_DECODER_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define BMP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bmp_pkg.sv]
// Package with types and constants for the BMP stream decoder
`timescale 1ns / 1ps
package bmp_pkg;
    localparam int MaxDim       = 4096;
    localparam int PaletteDepth = 256;
    localparam int PalAw        = $clog2(PaletteDepth);

    localparam logic [15:0] Signature   = 16'h4d42;
    localparam logic [31:0] InfoHdrSize = 32'd40;
    localparam logic [31:0] CoreHdrSize = 32'd12;
    localparam logic [8:0]  FullPalette = 9'd256;

    localparam logic       OpData = 1'b0;
    localparam logic       OpEof  = 1'b1;

    localparam logic [1:0] KindPixel = 2'd0;
    localparam logic [1:0] KindDone  = 2'd1;
    localparam logic [1:0] KindError = 2'd2;

    localparam logic [2:0] ErrSignature = 3'd0;
    localparam logic [2:0] ErrHdrSize   = 3'd1;
    localparam logic [2:0] ErrDepth     = 3'd2;
    localparam logic [2:0] ErrCompress  = 3'd3;
    localparam logic [2:0] ErrTruncated = 3'd4;
    localparam logic [2:0] ErrSizeLimit = 3'd5;

    typedef enum logic [2:0] {
        PH_FILE, PH_INFO, PH_PAL, PH_PIX, PH_PAD, PH_DONE, PH_HALT
    } t_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [2:0]  error_code;
    } t_out_item;

    // Palette write request from parser to memory
    typedef struct packed {
        logic             wr_en;
        logic [PalAw-1:0] wr_addr;
        logic [23:0]      wr_data;
    } t_pal_wr;

    // Lookup request travelling with a pixel beat into the read stage
    typedef struct packed {
        logic        valid;
        logic        use_pal;
        logic        hit;
        t_out_item   item;
    } t_pix_req;
endpackage

[rtl/bmp_palette_ram.sv]
// Palette memory with one write port and one registered read port
`timescale 1ns / 1ps
module bmp_palette_ram (
    input  logic                    i_clk,
    input  bmp_pkg::t_pal_wr        i_wr,
    input  logic                    i_rd_en,
    input  logic [bmp_pkg::PalAw-1:0] i_rd_addr,
    output logic [23:0]             o_rd_data
);
    import bmp_pkg::*;

    logic [23:0] r_mem [PaletteDepth];

    // Write an entry; read is registered
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_mem[i_wr.wr_addr] <= i_wr.wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

[rtl/bmp_parser.sv]
// Header parser and pixel sequencer of the BMP stream decoder
`timescale 1ns / 1ps
module bmp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  bmp_pkg::t_in_item    i_item,
    output bmp_pkg::t_pal_wr     o_pal_wr,
    output logic [bmp_pkg::PalAw-1:0] o_rd_addr,
    output bmp_pkg::t_pix_req    o_req,
    output bmp_pkg::t_phase      o_phase
);
    import bmp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_bcnt, n_bcnt;
    logic [31:0] r_word;
    logic        r_core, n_core;
    logic [31:0] r_width, n_width, r_height, n_height;
    logic [4:0]  r_bpp, n_bpp;
    logic [8:0]  r_ccount, n_ccount;
    logic [8:0]  r_pidx, n_pidx;
    logic [15:0] r_held, n_held;
    logic [1:0]  r_comp, n_comp;
    logic [11:0] r_col, n_col, r_row, n_row;
    logic [1:0]  r_pad, n_pad;
    logic [31:0] w;
    logic [7:0]  b;
    logic        eof;
    logic [15:0] d;
    logic [1:0]  rem;
    logic [12:0] col_inc;
    logic [2:0]  last_comp;
    t_pix_req    req;
    t_pal_wr     pw;

    assign b   = i_item.data_byte;
    assign eof = i_item.op == OpEof;
    assign w   = {b, r_word[31:8]};
    assign d   = w[31:16];
    // One extra bit so a row of MaxDim columns still ends
    assign col_inc = {1'b0, r_col} + 13'd1;
    assign last_comp = r_core ? 3'd2 : 3'd3;

    // Sequence header, palette and pixel bytes
    always_comb begin
        n_phase = r_phase; n_bcnt = r_bcnt; n_core = r_core;
        n_width = r_width; n_height = r_height; n_bpp = r_bpp;
        n_ccount = r_ccount; n_pidx = r_pidx; n_held = r_held;
        n_comp = r_comp; n_col = r_col; n_row = r_row; n_pad = r_pad;
        req = '0;
        pw  = '0;
        rem = '0;
        if (eof) begin
            req.valid = (r_phase != PH_HALT);
            req.item.kind = (r_phase == PH_DONE) ? KindDone : KindError;
            req.item.error_code = (r_phase == PH_DONE) ? 3'd0 : ErrTruncated;
            n_phase = PH_FILE; n_bcnt = '0; n_core = 1'b0;
            n_width = '0; n_height = '0; n_bpp = '0; n_ccount = '0;
            n_pidx = '0; n_held = '0; n_comp = '0; n_col = '0; n_row = '0;
            n_pad = '0;
        end else begin
            case (r_phase)
                PH_FILE: begin
                    n_bcnt = r_bcnt + 6'd1;
                    if (r_bcnt == 6'd1 && d != Signature) begin
                        n_phase = PH_HALT; req.valid = 1'b1;
                        req.item.kind = KindError; req.item.error_code = ErrSignature;
                    end else if (r_bcnt == 6'd17) begin
                        if (w == CoreHdrSize || w == InfoHdrSize) begin
                            n_core = (w == CoreHdrSize);
                            n_phase = PH_INFO; n_bcnt = '0;
                        end else begin
                            n_phase = PH_HALT; req.valid = 1'b1;
                            req.item.kind = KindError; req.item.error_code = ErrHdrSize;
                        end
                    end
                end
                PH_INFO: begin
                    n_bcnt = r_bcnt + 6'd1;
                    if (r_core) begin
                        if (r_bcnt == 6'd1) n_width = {16'd0, d};
                        if (r_bcnt == 6'd3) n_height = {16'd0, d};
                        if (r_bcnt == 6'd7) begin
                            if (d != 16'd8 && d != 16'd24) begin
                                n_phase = PH_HALT; req.valid = 1'b1;
                                req.item.kind = KindError; req.item.error_code = ErrDepth;
                            end else if (r_width > MaxDim || r_height > MaxDim) begin
                                n_bpp = d[4:0];
                                n_phase = PH_HALT; req.valid = 1'b1;
                                req.item.kind = KindError;
                                req.item.error_code = ErrSizeLimit;
                            end else begin
                                n_bpp = d[4:0];
                                n_ccount = (d == 16'd8) ? FullPalette : 9'd0;
                                n_pidx = '0; n_comp = '0;
                                if (d == 16'd8) n_phase = PH_PAL;
                                else if (r_width == 0 || r_height == 0) n_phase = PH_DONE;
                                else begin
                                    n_row = r_height[11:0] - 12'd1; n_col = '0;
                                    n_phase = PH_PIX;
                                end
                            end
                        end
                    end else begin
                        if (r_bcnt == 6'd3) n_width = w;
                        if (r_bcnt == 6'd7) n_height = w;
                        if (r_bcnt == 6'd11) begin
                            if (d != 16'd8 && d != 16'd24) begin
                                n_phase = PH_HALT; req.valid = 1'b1;
                                req.item.kind = KindError; req.item.error_code = ErrDepth;
                            end else n_bpp = d[4:0];
                        end
                        if (r_bcnt == 6'd15 && w != 32'd0) begin
                            n_phase = PH_HALT; req.valid = 1'b1;
                            req.item.kind = KindError; req.item.error_code = ErrCompress;
                        end
                        if (r_bcnt == 6'd31) begin
                            if (r_width > MaxDim || r_height > MaxDim || w > 32'd256) begin
                                n_phase = PH_HALT; req.valid = 1'b1;
                                req.item.kind = KindError;
                                req.item.error_code = ErrSizeLimit;
                            end else if (w != 0) n_ccount = w[8:0];
                            else n_ccount = (r_bpp == 5'd8) ? FullPalette : 9'd0;
                        end
                        if (r_bcnt == 6'd35) begin
                            n_pidx = '0; n_comp = '0;
                            if (r_ccount != 0) n_phase = PH_PAL;
                            else if (r_width == 0 || r_height == 0) n_phase = PH_DONE;
                            else begin
                                n_row = r_height[11:0] - 12'd1; n_col = '0;
                                n_phase = PH_PIX;
                            end
                        end
                    end
                end
                PH_PAL: begin
                    if (r_comp == 2'd0) n_held = {r_held[15:8], b};
                    if (r_comp == 2'd1) n_held = {b, r_held[7:0]};
                    if (r_comp == 2'd2 && r_pidx < PaletteDepth) begin
                        pw.wr_en = 1'b1;
                        pw.wr_addr = r_pidx[PalAw-1:0];
                        pw.wr_data = {b, r_held};
                    end
                    n_comp = r_comp + 2'd1;
                    if ({1'b0, r_comp} == last_comp) begin
                        n_comp = '0;
                        n_pidx = r_pidx + 9'd1;
                        if (n_pidx >= r_ccount) begin
                            if (r_width == 0 || r_height == 0) n_phase = PH_DONE;
                            else begin
                                n_row = r_height[11:0] - 12'd1; n_col = '0;
                                n_phase = PH_PIX;
                            end
                        end
                    end
                end
                PH_PIX: begin
                    req.item.pos_x = r_col;
                    req.item.pos_y = r_row;
                    if (r_bpp == 5'd8 || r_comp == 2'd2) begin
                        req.valid = 1'b1;
                        if (r_bpp == 5'd8) begin
                            req.use_pal = 1'b1;
                            req.hit = ({1'b0, b} < r_pidx) && ({1'b0, b} < PaletteDepth);
                        end else begin
                            req.item.red = b;
                            req.item.green = r_held[15:8];
                            req.item.blue = r_held[7:0];
                        end
                        n_comp = '0;
                        n_col = col_inc[11:0];
                        if ({19'd0, col_inc} >= r_width) begin
                            rem = (r_bpp == 5'd8) ? r_width[1:0]
                                                  : r_width[1:0] + {r_width[0], 1'b0};
                            n_pad = 2'd0 - rem;
                            if (n_pad != 0) n_phase = PH_PAD;
                            else if (r_row == 0) n_phase = PH_DONE;
                            else begin
                                n_row = r_row - 12'd1; n_col = '0;
                            end
                        end
                    end else if (r_comp == 2'd0) begin
                        n_held = {r_held[15:8], b}; n_comp = 2'd1;
                    end else begin
                        n_held = {b, r_held[7:0]}; n_comp = 2'd2;
                    end
                end
                PH_PAD: begin
                    n_pad = r_pad - 2'd1;
                    if (n_pad == 0) begin
                        if (r_row == 0) n_phase = PH_DONE;
                        else begin
                            n_row = r_row - 12'd1; n_col = '0; n_comp = '0;
                            n_phase = PH_PIX;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Advance state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FILE; r_bcnt <= '0; r_word <= '0; r_core <= 1'b0;
            r_width <= '0; r_height <= '0; r_bpp <= '0; r_ccount <= '0;
            r_pidx <= '0; r_held <= '0; r_comp <= '0; r_col <= '0; r_row <= '0;
            r_pad <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase; r_bcnt <= n_bcnt; r_core <= n_core;
            r_word <= eof ? 32'd0 : w;
            r_width <= n_width; r_height <= n_height; r_bpp <= n_bpp;
            r_ccount <= n_ccount; r_pidx <= n_pidx; r_held <= n_held;
            r_comp <= n_comp; r_col <= n_col; r_row <= n_row; r_pad <= n_pad;
        end
    end

    assign o_pal_wr = i_fire ? pw : '0;
    assign o_req = i_fire ? req : '0;
    assign o_rd_addr = b[PalAw-1:0];
    assign o_phase = r_phase;
endmodule

[rtl/bmp_stream_decoder.sv]
// Top level of the BMP stream decoder
// A result is registered in stage 1 (held in the skid register first while the output stalls).
// Throughput: one byte per cycle while o_in_stall is low; the palette read and the output register overlap.
// The palette memory's registered read sets the single stage of latency.
// Reset (synchronous, active low) returns the parser to waiting for a file header.
// The palette memory is not cleared; only loaded entries are ever used for a colour.
`timescale 1ns / 1ps
module bmp_stream_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bmp_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bmp_pkg::t_out_item   o_out_data
);
    import bmp_pkg::*;
    `include "bmp_stream_decoder_assert.svh"

    logic        fire, s1_adv, s1_busy;
    t_pal_wr     pal_wr;
    t_pix_req    req, r_s1;
    t_phase      phase;
    logic [PalAw-1:0] rd_addr;
    logic [PalAw-1:0] ram_addr;
    logic [23:0] rd_data;
    t_out_item   s1_item;
    logic        r_sk_valid;
    t_out_item   r_sk_item;
    logic        r_sk_use_pal;
    logic        r_sk_hit;
    logic [PalAw-1:0] r_sk_addr;

    // Stage 1 holds until the output side takes it; skid catches one more
    assign s1_busy = r_s1.valid && (o_out_valid && i_out_stall);
    assign o_in_stall = r_sk_valid;
    assign fire = i_in_valid && !o_in_stall;
    assign s1_adv = !(r_s1.valid && i_out_stall);

    // Replay the held lookup address while the skid drains
    assign ram_addr = r_sk_valid ? r_sk_addr : rd_addr;

    bmp_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire), .i_item(i_in_data),
        .o_pal_wr(pal_wr), .o_rd_addr(rd_addr), .o_req(req), .o_phase(phase)
    );

    bmp_palette_ram u_ram (
        .i_clk(i_clk), .i_wr(pal_wr), .i_rd_en(s1_adv || !r_s1.valid),
        .i_rd_addr(ram_addr), .o_rd_data(rd_data)
    );

    // Merge palette colour into the stage-1 result
    always_comb begin
        s1_item = r_s1.item;
        if (r_s1.use_pal && r_s1.hit) begin
            s1_item.red = rd_data[23:16];
            s1_item.green = rd_data[15:8];
            s1_item.blue = rd_data[7:0];
        end
    end

    // Stage 1 register; a beat arriving while stalled goes to the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_s1.valid || !i_out_stall) begin
            if (r_sk_valid) begin
                r_s1.valid <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_s1.valid <= req.valid;
            end
        end else if (req.valid) begin
            r_sk_valid <= 1'b1;
        end

        if (!r_s1.valid || !i_out_stall) begin
            if (r_sk_valid) begin
                r_s1.use_pal <= r_sk_use_pal; r_s1.hit <= r_sk_hit;
                r_s1.item <= r_sk_item;
            end else begin
                r_s1.use_pal <= req.use_pal; r_s1.hit <= req.hit; r_s1.item <= req.item;
            end
        end else if (req.valid) begin
            r_sk_item <= req.item;
            r_sk_use_pal <= req.use_pal;
            r_sk_hit <= req.hit;
            r_sk_addr <= rd_addr;
        end
    end

    assign o_out_valid = r_s1.valid;
    assign o_out_data = s1_item;

    `BMP_ASSERT_IMP(a_no_skid_overflow, r_sk_valid && r_s1.valid, !fire || !req.valid,
        "beat accepted while skid full")
    `BMP_ASSERT_NEXT(a_halt_silent, fire && phase == PH_HALT && !i_in_data.op,
        !r_sk_valid || $past(r_sk_valid), "halted decoder produced a result")
    `BMP_ASSERT_IMP(a_busy_consistent, s1_busy, o_out_valid,
        "stage busy without valid")
endmodule

[sim/bmp_stream_decoder_checker.sv]
// Checker that predicts and compares the pixel stream of the BMP stream decoder
`timescale 1ns / 1ps
module bmp_stream_decoder_checker
    import bmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);
    // Decoder state mirrored beat by beat
    t_phase      phase;
    logic [5:0]  hdr_pos;
    logic [31:0] word;
    logic        core_hdr;
    logic [31:0] img_w;
    logic [31:0] img_h;
    int          depth;
    int          colours;
    int          pal_fill;
    logic [23:0] palette [256];
    logic [15:0] held;
    int          comp;
    int          col;
    int          row;
    int          pad_left;

    t_out_item   expected_px[$];

    function automatic void restart();
        phase    = PH_FILE;
        hdr_pos  = '0;
        word     = '0;
        core_hdr = 1'b0;
        img_w    = '0;
        img_h    = '0;
        depth    = 0;
        colours  = 0;
        pal_fill = 0;
        held     = '0;
        comp     = 0;
        col      = 0;
        row      = 0;
        pad_left = 0;
    endfunction

    function automatic t_out_item fault(input logic [2:0] code);
        t_out_item r;
        r = '0;
        r.kind = KindError;
        r.error_code = code;
        phase = PH_HALT;
        return r;
    endfunction

    function automatic void begin_pixels();
        if (img_w == 0 || img_h == 0) begin
            phase = PH_DONE;
            return;
        end
        row   = img_h - 1;
        col   = 0;
        comp  = 0;
        phase = PH_PIX;
    endfunction

    function automatic void end_header();
        pal_fill = 0;
        comp     = 0;
        if (colours == 0) begin_pixels();
        else phase = PH_PAL;
    endfunction

    function automatic void end_row();
        if (row == 0) begin
            phase = PH_DONE;
        end else begin
            row--;
            col   = 0;
            comp  = 0;
            phase = PH_PIX;
        end
    endfunction

    function automatic void end_pixel();
        logic [31:0] rem;
        col++;
        if (col < img_w) return;
        rem = (depth == 8) ? (img_w & 3) : ((img_w * 3) & 3);
        pad_left = (4 - rem) & 3;
        if (pad_left != 0) phase = PH_PAD;
        else end_row();
    endfunction

    // Advance the decoder by one beat; return 1 when a result is due
    function automatic bit decode_beat(input t_in_item it, output t_out_item res);
        logic [7:0]  b;
        int          p;
        logic [15:0] hi;
        logic [23:0] c;
        bit          got;
        b   = it.data_byte;
        res = '0;
        if (it.op == OpEof) begin
            got = 1'b0;
            if (phase == PH_DONE) begin
                res.kind = KindDone;
                got = 1'b1;
            end else if (phase != PH_HALT) begin
                res.kind = KindError;
                res.error_code = ErrTruncated;
                got = 1'b1;
            end
            restart();
            return got;
        end
        word = {b, word[31:8]};
        p    = hdr_pos;
        hi   = word[31:16];
        case (phase)
            PH_FILE: begin
                hdr_pos = p + 1;
                if (p == 1 && hi != Signature) begin
                    res = fault(ErrSignature);
                    return 1'b1;
                end
                if (p == 17) begin
                    if (word == CoreHdrSize) core_hdr = 1'b1;
                    else if (word == InfoHdrSize) core_hdr = 1'b0;
                    else begin
                        res = fault(ErrHdrSize);
                        return 1'b1;
                    end
                    phase   = PH_INFO;
                    hdr_pos = '0;
                end
            end
            PH_INFO: begin
                hdr_pos = p + 1;
                if (core_hdr) begin
                    if (p == 1) img_w = hi;
                    if (p == 3) img_h = hi;
                    if (p == 7) begin
                        if (hi != 8 && hi != 24) begin
                            res = fault(ErrDepth);
                            return 1'b1;
                        end
                        depth = hi;
                        if (img_w > 32'(MaxDim) || img_h > 32'(MaxDim)) begin
                            res = fault(ErrSizeLimit);
                            return 1'b1;
                        end
                        colours = (hi == 8) ? 256 : 0;
                        end_header();
                    end
                end else begin
                    if (p == 3) img_w = word;
                    if (p == 7) img_h = word;
                    if (p == 11) begin
                        if (hi != 8 && hi != 24) begin
                            res = fault(ErrDepth);
                            return 1'b1;
                        end
                        depth = hi;
                    end
                    if (p == 15 && word != 0) begin
                        res = fault(ErrCompress);
                        return 1'b1;
                    end
                    if (p == 31) begin
                        if (img_w > 32'(MaxDim) || img_h > 32'(MaxDim) || word > 32'd256) begin
                            res = fault(ErrSizeLimit);
                            return 1'b1;
                        end
                        colours = (word != 0) ? int'(word) : ((depth == 8) ? 256 : 0);
                    end
                    if (p == 35) end_header();
                end
            end
            PH_PAL: begin
                if (comp == 0) held = {8'h00, b};
                else if (comp == 1) held[15:8] = b;
                else if (comp == 2 && pal_fill < PaletteDepth) palette[pal_fill] = {b, held};
                comp++;
                if (comp >= (core_hdr ? 3 : 4)) begin
                    comp = 0;
                    pal_fill++;
                    if (pal_fill >= colours) begin_pixels();
                end
            end
            PH_PIX: begin
                res.kind  = KindPixel;
                res.pos_x = col[11:0];
                res.pos_y = row[11:0];
                if (depth == 8) begin
                    c = '0;
                    if (b < pal_fill && b < PaletteDepth) c = palette[b];
                    {res.red, res.green, res.blue} = c;
                    end_pixel();
                    return 1'b1;
                end
                if (comp == 0) begin
                    held = {8'h00, b};
                    comp = 1;
                    return 1'b0;
                end
                if (comp == 1) begin
                    held[15:8] = b;
                    comp = 2;
                    return 1'b0;
                end
                comp = 0;
                res.red   = b;
                res.green = held[15:8];
                res.blue  = held[7:0];
                end_pixel();
                return 1'b1;
            end
            PH_PAD: begin
                pad_left = (pad_left - 1) & 3;
                if (pad_left == 0) end_row();
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    assign o_pending = expected_px.size();

    // Compare delivered beats, then predict from accepted ones
    always @(posedge i_clk) begin
        t_out_item exp_item;
        t_out_item got;
        if (!i_rst_n) begin
            restart();
            expected_px.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_px.size() == 0) begin
                    $error("unexpected result beat %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = expected_px.pop_front();
                    if (got !== exp_item) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.kind !== exp_item.kind)
                            $error("kind: expected %0d got %0d", exp_item.kind, got.kind);
                        if (got.red !== exp_item.red)
                            $error("red: expected %0d got %0d", exp_item.red, got.red);
                        if (got.green !== exp_item.green)
                            $error("green: expected %0d got %0d", exp_item.green, got.green);
                        if (got.blue !== exp_item.blue)
                            $error("blue: expected %0d got %0d", exp_item.blue, got.blue);
                        if (got.pos_x !== exp_item.pos_x)
                            $error("pos_x: expected %0d got %0d", exp_item.pos_x, got.pos_x);
                        if (got.pos_y !== exp_item.pos_y)
                            $error("pos_y: expected %0d got %0d", exp_item.pos_y, got.pos_y);
                        if (got.error_code !== exp_item.error_code)
                            $error("error_code: expected %0d got %0d",
                                   exp_item.error_code, got.error_code);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_beat(i_in_data, exp_item)) expected_px.push_back(exp_item);
            end
        end
    end
endmodule

[sim/bmp_stream_decoder_tb.sv]
// Testbench top for the BMP stream decoder: file stimulus, stalls and verdict
`timescale 1ns / 1ps
module bmp_stream_decoder_tb;
    import bmp_pkg::*;

    localparam int CycleLimit = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        beats_sent;
    int        cycles;
    int        burst_left;
    logic [7:0] file_bytes[$];

    bmp_stream_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    bmp_stream_decoder_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the result side in changing moods, with one long hold-off
    initial begin
        int mood;
        bit held_off;
        held_off = 1'b0;
        out_stall = 1'b0;
        forever begin
            mood = $urandom_range(0, 2);
            repeat ($urandom_range(16, 96)) begin
                @(posedge i_clk);
                if (!held_off && beats_sent >= 300) begin
                    held_off = 1'b1;
                    out_stall <= 1'b1;
                    repeat (600) @(posedge i_clk);
                end
                case (mood)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Offer one beat, holding it until taken
    task automatic send_beat(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: op, data_byte: b};
        do @(posedge i_clk); while (in_stall);
        beats_sent++;
        burst_left--;
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_beat(OpData, file_bytes[i]);
        send_beat(OpEof, 8'($urandom));
    endtask

    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    // Assemble a file; pixel data only for small images
    function automatic void build_file(input bit core, input logic [31:0] w,
                                       input logic [31:0] h, input int bpp,
                                       input logic [31:0] comp, input logic [31:0] used,
                                       input int trail);
        int n;
        int row_bytes;
        file_bytes.delete();
        file_bytes.push_back(8'h42);
        file_bytes.push_back(8'h4d);
        put_le($urandom, 4);
        put_le(0, 4);
        put_le($urandom, 4);
        put_le(core ? CoreHdrSize : InfoHdrSize, 4);
        if (core) begin
            put_le(w, 2);
            put_le(h, 2);
            put_le(1, 2);
            put_le(bpp, 2);
            n = (bpp == 8) ? 256 : 0;
        end else begin
            put_le(w, 4);
            put_le(h, 4);
            put_le(1, 2);
            put_le(bpp, 2);
            put_le(comp, 4);
            put_le($urandom, 4);
            put_le($urandom, 4);
            put_le($urandom, 4);
            put_le(used, 4);
            put_le(0, 4);
            n = (used != 0) ? int'(used) : ((bpp == 8) ? 256 : 0);
        end
        if (n > 256) n = 0;
        repeat (n * (core ? 3 : 4)) file_bytes.push_back(8'($urandom));
        if (w != 0 && h != 0 && w <= 64 && h <= 64) begin
            row_bytes = w * bpp / 8;
            for (int r = 0; r < h; r++) begin
                for (int k = 0; k < row_bytes; k++) begin
                    if (bpp == 8 && n > 0 && $urandom_range(0, 3) != 0)
                        file_bytes.push_back(8'($urandom_range(0, n - 1)));
                    else
                        file_bytes.push_back(8'($urandom));
                end
                repeat ((4 - row_bytes % 4) % 4) file_bytes.push_back(8'($urandom));
            end
        end
        repeat (trail) file_bytes.push_back(8'($urandom));
    endfunction

    // Random well-formed file of small size
    function automatic void random_file();
        bit core;
        int bpp;
        logic [31:0] used;
        core = ($urandom_range(0, 3) == 0);
        bpp  = ($urandom_range(0, 1) == 0) ? 8 : 24;
        if (core && bpp == 8 && $urandom_range(0, 3) != 0) bpp = 24;
        if (bpp == 8) used = $urandom_range(1, 20);
        else used = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        build_file(core, $urandom_range(0, 9), $urandom_range(0, 5), bpp, 0, used,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    endfunction

    initial begin
        int idx;
        in_valid   = 1'b0;
        in_data    = '0;
        beats_sent = 0;
        cycles     = 0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: end of file before any byte
        file_bytes.delete();
        send_file();
        // Bad signature
        file_bytes = '{8'h42, 8'h00, 8'h11};
        send_file();
        // Bad header size
        build_file(0, 2, 2, 24, 0, 0, 0);
        file_bytes[14] = 8'd41;
        send_file();
        // Unsupported depth, info and core
        build_file(0, 2, 2, 16, 0, 0, 0);
        send_file();
        build_file(1, 2, 2, 32, 0, 0, 0);
        send_file();
        // Compressed
        build_file(0, 2, 2, 24, 1, 0, 0);
        send_file();
        // Size limit: wide, negative height, too many colours, core wide
        build_file(0, 4097, 1, 24, 0, 0, 0);
        send_file();
        build_file(0, 1, 32'hFFFF_FFFE, 24, 0, 0, 0);
        send_file();
        build_file(0, 1, 1, 8, 0, 257, 0);
        send_file();
        build_file(1, 4097, 1, 24, 0, 0, 0);
        send_file();
        // Empty image at the largest width, then trailing bytes
        build_file(0, 4096, 0, 24, 0, 0, 5);
        send_file();
        // Full palette from a zero colour count
        build_file(0, 2, 2, 8, 0, 0, 0);
        send_file();
        // Unloaded indices with a two-entry palette
        build_file(0, 5, 3, 8, 0, 2, 3);
        send_file();
        // Padded 24-bit rows with trailing bytes
        build_file(0, 5, 3, 24, 0, 0, 7);
        send_file();
        // Truncated in the pixel data
        build_file(0, 6, 4, 24, 0, 0, 0);
        file_bytes = file_bytes[0:file_bytes.size() - 10];
        send_file();

        // Random: mostly well-formed files, some damaged or noise
        while (beats_sent < 1900) begin
            random_file();
            case ($urandom_range(0, 7))
                0: begin
                    idx = $urandom_range(0, 40);
                    if (idx < file_bytes.size())
                        file_bytes[idx] ^= 8'($urandom_range(1, 255));
                end
                1: begin
                    idx = $urandom_range(0, file_bytes.size() - 1);
                    file_bytes = file_bytes[0:idx];
                end
                2: begin
                    file_bytes.delete();
                    repeat ($urandom_range(0, 30)) file_bytes.push_back(8'($urandom));
                end
                default: ;
            endcase
            send_file();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
